>>> rtl/wec_pkg.sv
// Shared constants, codes and control structs of the wheel encoder counter.
package wec_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int AVERAGE_TAPS   = 3;
  localparam int COUNT_BITS     = 32;

  localparam int THR_BITS       = 10;
  localparam int GAP_US_BITS    = 20;
  localparam int GAP_MS_BITS    = 16;
  localparam int SCALE_BITS     = 16;
  localparam int TIME_BITS      = 32;
  localparam int VEL_BITS       = 32;

  localparam int SUM_BITS       = SAMPLE_BITS + 2;
  localparam int CMP_BITS       = (SUM_BITS > THR_BITS + 2) ? SUM_BITS : THR_BITS + 2;

  // signed count change times unsigned scale
  localparam int PROD_BITS      = COUNT_BITS + SCALE_BITS;
  localparam int MAG_BITS       = PROD_BITS - 1;
  localparam int SAT_BITS       = (MAG_BITS > VEL_BITS) ? MAG_BITS : VEL_BITS + 1;
  localparam int DIV_CNT_BITS   = $clog2(MAG_BITS + 1);

  localparam logic [SAT_BITS-1:0] SAT_POS_MAX = SAT_BITS'((64'd1 << (VEL_BITS - 1)) - 64'd1);
  localparam logic [SAT_BITS-1:0] SAT_NEG_MAX = SAT_BITS'(64'd1 << (VEL_BITS - 1));
  localparam logic [VEL_BITS-1:0] VEL_MAX     = {1'b0, {(VEL_BITS - 1){1'b1}}};
  localparam logic [VEL_BITS-1:0] VEL_MIN     = {1'b1, {(VEL_BITS - 1){1'b0}}};

  localparam int IN_FIELD_BITS  = SAMPLE_BITS + 2 * TIME_BITS + 1;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * VEL_BITS + 3;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = GAP_US_BITS;

  localparam logic [THR_BITS-1:0]    LOW_THR_RESET  = THR_BITS'(300);
  localparam logic [THR_BITS-1:0]    HIGH_THR_RESET = THR_BITS'(700);
  localparam logic [GAP_US_BITS-1:0] GAP_US_RESET   = GAP_US_BITS'(1000);
  localparam logic [GAP_MS_BITS-1:0] GAP_MS_RESET   = GAP_MS_BITS'(100);
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET    = SCALE_BITS'(1000);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOW_THR  = 3'd0,
    CFG_HIGH_THR = 3'd1,
    CFG_GAP_US   = 3'd2,
    CFG_GAP_MS   = 3'd3,
    CFG_SCALE    = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_start;
    logic fin;
    logic load_out;
  } wec_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic vel_gate;
    logic div_busy;
  } wec_status_t;

endpackage

>>> rtl/wheel_encoder_count_velocity.sv
// Top level of the wheel encoder pulse counter with velocity estimate.
//
//  channel  | direction | handshake              | content
//  ---------+-----------+------------------------+-------------------------------
//  s_       | in        | s_tvalid_i/s_tready_o  | update or clear request
//  m_       | out       | m_tvalid_o/m_tready_i  | count, velocity and flags
//  cfg_     | in        | cfg_valid_i/cfg_ready_o| register index and write data
//
//  A request without a velocity update passes ST_EVAL and ST_WRITE on its way to output.
//  With a velocity update it also passes ST_MUL, ST_DIV_START, ST_DIV_WAIT and ST_FIN,
//  where the restoring divider produces one of its 47 quotient bits per cycle.
//  One request is in flight at a time; the next is accepted once the result
//  is in the output register, even while that result waits for m_tready_i.
//  After reset the block accepts requests at once; config writes always complete.
module wheel_encoder_count_velocity (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // [9:0] sample, [41:10] time_us, [73:42] time_ms, [74] direction_negative
  input  logic [wec_pkg::IN_TDATA_BITS-1:0]  s_tdata_i,
  // [0] operation
  input  logic [0:0]                         s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // [31:0] count, [63:32] velocity, [64] level_high, [65] sample_taken,
  // [66] velocity_updated
  output logic [wec_pkg::OUT_TDATA_BITS-1:0] m_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wec_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [wec_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import wec_pkg::*;

  wec_cmd_t    cmd;
  wec_status_t status;

  logic [VEL_BITS-1:0] count, velocity;
  logic                level_high, sample_taken, velocity_updated;

  assign cfg_ready_o = 1'b1;

  wec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wec_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (s_tuser_i[0]),
    .sample_i             (s_tdata_i[SAMPLE_BITS-1:0]),
    .time_us_i            (s_tdata_i[SAMPLE_BITS +: TIME_BITS]),
    .time_ms_i            (s_tdata_i[SAMPLE_BITS+TIME_BITS +: TIME_BITS]),
    .direction_negative_i (s_tdata_i[SAMPLE_BITS+2*TIME_BITS]),
    .count_o              (count),
    .velocity_o           (velocity),
    .level_high_o         (level_high),
    .sample_taken_o       (sample_taken),
    .velocity_updated_o   (velocity_updated)
  );

  assign m_tdata_o = OUT_TDATA_BITS'({velocity_updated, sample_taken, level_high,
                                      velocity, count});

endmodule

>>> rtl/wec_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module wec_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wec_pkg::MAG_BITS-1:0]  dividend_i,
  input  logic [wec_pkg::TIME_BITS-1:0] divisor_i,
  output logic                          busy_o,
  output logic [wec_pkg::MAG_BITS-1:0]  quotient_o
);
  import wec_pkg::*;

  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [MAG_BITS-1:0]     quo_q, quo_d;
  logic [TIME_BITS-1:0]    rem_q, rem_d;
  logic [TIME_BITS-1:0]    div_q, div_d;
  logic [TIME_BITS:0]      shifted;
  logic [TIME_BITS:0]      diff;
  logic                    fits;

  assign shifted = {rem_q, quo_q[MAG_BITS-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    if (start_i) begin
      cnt_d = DIV_CNT_BITS'(MAG_BITS);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[MAG_BITS-2:0], fits};
      rem_d = fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

endmodule

>>> rtl/wec_datapath.sv
// Datapath: registers, state, sample filter, counter, multiplier and divider.
module wec_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wec_pkg::wec_cmd_t                  cmd_i,
  output wec_pkg::wec_status_t               status_o,
  input  logic                               cfg_we_i,
  input  logic [wec_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [wec_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               operation_i,
  input  logic [wec_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [wec_pkg::TIME_BITS-1:0]      time_us_i,
  input  logic [wec_pkg::TIME_BITS-1:0]      time_ms_i,
  input  logic                               direction_negative_i,
  output logic [wec_pkg::VEL_BITS-1:0]       count_o,
  output logic [wec_pkg::VEL_BITS-1:0]       velocity_o,
  output logic                               level_high_o,
  output logic                               sample_taken_o,
  output logic                               velocity_updated_o
);
  import wec_pkg::*;

  // configuration
  logic [THR_BITS-1:0]    low_thr_q, high_thr_q;
  logic [GAP_US_BITS-1:0] gap_us_q;
  logic [GAP_MS_BITS-1:0] gap_ms_q;
  logic [SCALE_BITS-1:0]  scale_q;

  // item held for the duration of its processing
  logic                   op_q, neg_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [TIME_BITS-1:0]   tus_q, tms_q;

  // architectural state
  logic [SAMPLE_BITS-1:0] prev1_q, prev2_q;
  logic                   level_q;
  logic [COUNT_BITS-1:0]  count_q, count_at_vel_q;
  logic [VEL_BITS-1:0]    vel_q;
  logic [TIME_BITS-1:0]   last_us_q, last_ms_q;
  logic                   taken_q, vupd_q;

  logic signed [PROD_BITS-1:0] prod_q;

  logic [VEL_BITS-1:0] out_count_q, out_vel_q;
  logic                out_level_q, out_taken_q, out_vupd_q;

  logic [TIME_BITS-1:0]        elapsed_us, elapsed_ms;
  logic                        gate_us;
  logic [CMP_BITS-1:0]         sum, low3, high3;
  logic                        is_low, is_high;
  logic [COUNT_BITS-1:0]       delta;
  logic signed [SCALE_BITS:0]  scale_s;
  logic signed [PROD_BITS-1:0] prod_d;
  logic [PROD_BITS-1:0]        prod_abs;
  logic [MAG_BITS-1:0]         quotient;
  logic                        div_busy;
  logic [SAT_BITS-1:0]         q_ext;
  logic [VEL_BITS-1:0]         q_low;
  logic [VEL_BITS-1:0]         vel_new;

  assign elapsed_us = tus_q - last_us_q;
  assign elapsed_ms = tms_q - last_ms_q;
  assign gate_us    = elapsed_us > TIME_BITS'(gap_us_q);

  assign sum     = CMP_BITS'(sample_q) + CMP_BITS'(prev1_q) + CMP_BITS'(prev2_q);
  assign low3    = CMP_BITS'(low_thr_q) * CMP_BITS'(AVERAGE_TAPS);
  assign high3   = CMP_BITS'(high_thr_q) * CMP_BITS'(AVERAGE_TAPS);
  assign is_low  = sum <= low3;
  assign is_high = sum >= high3;

  // count change since the last velocity update, read as signed
  assign delta   = count_q - count_at_vel_q;
  assign scale_s = $signed({1'b0, scale_q});
  assign prod_d  = $signed(delta) * scale_s;

  assign prod_abs = prod_q[PROD_BITS-1] ? PROD_BITS'(-prod_q) : PROD_BITS'(prod_q);

  wec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_abs[MAG_BITS-1:0]),
    .divisor_i  (elapsed_ms),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // truncated quotient with the product's sign, saturated
  always_comb begin
    q_ext = SAT_BITS'(quotient);
    q_low = q_ext[VEL_BITS-1:0];
    if (!prod_q[PROD_BITS-1]) begin
      vel_new = (q_ext > SAT_POS_MAX) ? VEL_MAX : q_low;
    end else begin
      vel_new = (q_ext > SAT_NEG_MAX) ? VEL_MIN : VEL_BITS'(-q_low);
    end
  end

  assign status_o.op_clear = op_q == OP_CLEAR;
  assign status_o.vel_gate = elapsed_ms > TIME_BITS'(gap_ms_q);
  assign status_o.div_busy = div_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RESET;
      high_thr_q <= HIGH_THR_RESET;
      gap_us_q   <= GAP_US_RESET;
      gap_ms_q   <= GAP_MS_RESET;
      scale_q    <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOW_THR:  low_thr_q  <= cfg_data_i[THR_BITS-1:0];
        CFG_HIGH_THR: high_thr_q <= cfg_data_i[THR_BITS-1:0];
        CFG_GAP_US:   gap_us_q   <= cfg_data_i[GAP_US_BITS-1:0];
        CFG_GAP_MS:   gap_ms_q   <= cfg_data_i[GAP_MS_BITS-1:0];
        CFG_SCALE:    scale_q    <= cfg_data_i[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q        <= '0;
      prev2_q        <= '0;
      level_q        <= 1'b1;
      count_q        <= '0;
      count_at_vel_q <= '0;
      vel_q          <= '0;
      last_us_q      <= '0;
      last_ms_q      <= '0;
      taken_q        <= 1'b0;
      vupd_q         <= 1'b0;
    end else if (cmd_i.eval) begin
      taken_q <= 1'b0;
      vupd_q  <= 1'b0;
      if (op_q == OP_CLEAR) begin
        count_q <= '0;
        vel_q   <= '0;
      end else if (gate_us) begin
        taken_q   <= 1'b1;
        prev1_q   <= sample_q;
        prev2_q   <= prev1_q;
        last_us_q <= tus_q;
        priority if (is_low) begin
          level_q <= 1'b0;
        end else if (is_high && !level_q) begin
          level_q <= 1'b1;
          count_q <= neg_q ? count_q - 1'b1 : count_q + 1'b1;
        end else begin
          level_q <= level_q;
        end
      end
    end else if (cmd_i.fin) begin
      vel_q          <= vel_new;
      count_at_vel_q <= count_q;
      last_ms_q      <= tms_q;
      vupd_q         <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      sample_q <= sample_i;
      tus_q    <= time_us_i;
      tms_q    <= time_ms_i;
      neg_q    <= direction_negative_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.load_out) begin
      out_count_q <= VEL_BITS'($signed(count_q));
      out_vel_q   <= vel_q;
      out_level_q <= level_q;
      out_taken_q <= taken_q;
      out_vupd_q  <= vupd_q;
    end
  end

  assign count_o            = out_count_q;
  assign velocity_o         = out_vel_q;
  assign level_high_o       = out_level_q;
  assign sample_taken_o     = out_taken_q;
  assign velocity_updated_o = out_vupd_q;

endmodule

>>> rtl/wec_ctrl.sv
// Controller: sequences one item through filter, multiply, divide and output.
module wec_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  wec_pkg::wec_status_t status_i,
  output wec_pkg::wec_cmd_t    cmd_o
);
  import wec_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FIN,
    ST_WRITE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || m_tready_i;
  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.eval      = state_q == ST_EVAL;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.div_start = state_q == ST_DIV_START;
    cmd_o.fin       = state_q == ST_FIN;
    cmd_o.load_out  = (state_q == ST_WRITE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          // the velocity gate does not depend on the sample update
          if (!status_i.op_clear && status_i.vel_gate) state_q <= ST_MUL;
          else state_q <= ST_WRITE;
        end
        ST_MUL:       state_q <= ST_DIV_START;
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (!status_i.div_busy) state_q <= ST_FIN;
        end
        ST_FIN:       state_q <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default:      state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/wec_checker.sv
// Port-level checks of the wheel encoder counter, bound to its top level.
module wec_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tvalid_i,
  input logic                               s_tready_o,
  input logic                               m_tvalid_o,
  input logic                               m_tready_i,
  input logic [wec_pkg::OUT_TDATA_BITS-1:0] m_tdata_o
);
  import wec_pkg::*;

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request accepted while previous one still in work");

  // a new result appears exactly as the block returns to idle
  a_result_with_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> s_tready_o)
    else $error("result presented while request still in work");

  // a result is only produced after a request was accepted
  a_result_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> !$past(s_tready_o))
    else $error("result without a request");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result dropped or changed");

endmodule

bind wheel_encoder_count_velocity wec_checker u_wec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
